// File: rtl/ppts_pkg.sv
package ppts_pkg;

  localparam int unsigned DefLevels = 4;
  localparam int unsigned DefSlots  = 4;

  localparam int unsigned TickW    = 6;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  localparam logic [2:0] OpAdd     = 3'd0;
  localparam logic [2:0] OpDelete  = 3'd1;
  localparam logic [2:0] OpSuspend = 3'd2;
  localparam logic [2:0] OpResume  = 3'd3;
  localparam logic [2:0] OpTick    = 3'd4;

  localparam logic [2:0] ResAdded     = 3'd0;
  localparam logic [2:0] ResNotAdded  = 3'd1;
  localparam logic [2:0] ResDone      = 3'd2;
  localparam logic [2:0] ResFired     = 3'd3;
  localparam logic [2:0] ResNoneFired = 3'd4;

  localparam logic [1:0] StReady     = 2'd0;
  localparam logic [1:0] StWaiting   = 2'd1;
  localparam logic [1:0] StSuspended = 2'd2;

  typedef struct packed {
    logic [15:0] first_delay_ms;
    logic [15:0] period_ms;
    logic [7:0]  priority_req;
    logic [7:0]  task_id;
    logic [2:0]  operation;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic [7:0]  fired_priority;
    logic [7:0]  fired_task_id;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  ident;
  } entry_t;

endpackage

// File: rtl/ppts_alu.sv
module ppts_alu (
  input  logic [15:0]               a_i,
  input  logic [ppts_pkg::TickW-1:0] b_i,
  output logic                      le_o,
  output logic [15:0]               diff_o
);
  import ppts_pkg::*;

  logic [16:0] diff;

  assign diff   = {1'b0, a_i} - {{(17 - TickW){1'b0}}, b_i};
  assign le_o   = diff[16] || (diff[15:0] == 16'd0);
  assign diff_o = diff[15:0];

endmodule

// File: rtl/ppts_table.sv
module ppts_table #(
  parameter int unsigned Entries = 16,
  parameter int unsigned EW      = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  re_i,
  input  logic [EW-1:0]         raddr_i,
  output ppts_pkg::entry_t      rdata_o,
  input  logic                  we_i,
  input  logic [EW-1:0]         waddr_i,
  input  ppts_pkg::entry_t      wdata_i,
  input  logic                  vset_i,
  input  logic                  vclr_i,
  input  logic [EW-1:0]         vidx_i,
  output logic [Entries-1:0]    valid_o
);
  import ppts_pkg::*;

  entry_t               mem_q [Entries];
  entry_t               rd_q;
  logic                 rd_ok_q;
  logic [Entries-1:0]   written_q;
  logic [Entries-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // An entry never written reads as all zero, as after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      valid_q   <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (re_i) begin
        rd_ok_q <= written_q[raddr_i];
      end
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (vset_i) begin
        valid_q[vidx_i] <= 1'b1;
      end else if (vclr_i) begin
        valid_q[vidx_i] <= 1'b0;
      end
    end
  end

  assign rdata_o = rd_ok_q ? rd_q : '0;
  assign valid_o = valid_q;

endmodule

// File: rtl/ppts_seq.sv
module ppts_seq #(
  parameter int unsigned Levels  = 4,
  parameter int unsigned Slots   = 4,
  parameter int unsigned Entries = 16,
  parameter int unsigned EW      = 4,
  parameter int unsigned LW      = 2,
  parameter int unsigned SW      = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ppts_pkg::in_item_t         in_item_i,
  input  logic [ppts_pkg::TickW-1:0] tick_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ppts_pkg::out_item_t        out_item_o,
  output logic                       tbl_re_o,
  output logic [EW-1:0]              tbl_addr_o,
  input  ppts_pkg::entry_t           tbl_rdata_i,
  output logic                       tbl_we_o,
  output ppts_pkg::entry_t           tbl_wdata_o,
  output logic                       tbl_vset_o,
  output logic                       tbl_vclr_o,
  input  logic [Entries-1:0]         tbl_valid_i
);
  import ppts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ACT_RD,
    S_ACT_EV,
    S_TK_RD,
    S_TK_EV,
    S_FIN
  } state_e;

  state_e       state_q, state_d;
  logic [2:0]   op_q, op_d;
  logic [7:0]   id_q, id_d;
  logic [15:0]  period_q, period_d;
  logic [15:0]  delay_q, delay_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [SW-1:0] sl_q, sl_d;
  logic [EW-1:0] e_q, e_d;
  logic         found_q, found_d;
  out_item_t    pend_q, pend_d;
  logic         pend_fire_q, pend_fire_d;
  out_item_t    out_q, out_d;
  logic         out_valid_q, out_valid_d;

  logic         out_free;
  logic         last_slot;
  logic         last_lv;
  logic         fire;
  logic         waiting;
  logic [15:0]  operand;
  logic         le;
  logic [15:0]  diff;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_slot = (sl_q == SW'(Slots - 1));
  assign last_lv   = (lv_q == LW'(Levels - 1));
  assign fire      = tbl_valid_i[e_q] && (tbl_rdata_i.st == StReady);
  assign waiting   = tbl_valid_i[e_q] && (tbl_rdata_i.st == StWaiting);
  assign operand   = (tbl_rdata_i.st == StReady) ? tbl_rdata_i.period : tbl_rdata_i.delay;

  ppts_alu u_alu (
    .a_i    (operand),
    .b_i    (tick_ms_i),
    .le_o   (le),
    .diff_o (diff)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    period_d    = period_q;
    delay_d     = delay_q;
    lv_d        = lv_q;
    sl_d        = sl_q;
    e_d         = e_q;
    found_d     = found_q;
    pend_d      = pend_q;
    pend_fire_d = pend_fire_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tbl_re_o    = 1'b0;
    tbl_we_o    = 1'b0;
    tbl_wdata_o = tbl_rdata_i;
    tbl_vset_o  = 1'b0;
    tbl_vclr_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.operation;
          id_d     = in_item_i.task_id;
          period_d = in_item_i.period_ms;
          delay_d  = in_item_i.first_delay_ms;
          lv_d     = '0;
          sl_d     = '0;
          e_d      = '0;
          found_d  = 1'b0;
          pend_d   = '0;
          pend_fire_d = 1'b0;
          unique case (in_item_i.operation)
            OpAdd: begin
              if (32'(in_item_i.priority_req) < Levels) begin
                e_d     = EW'(32'(in_item_i.priority_req) * Slots);
                state_d = S_ADD;
              end else begin
                pend_d.status = ResNotAdded;
                state_d       = S_FIN;
              end
            end
            OpDelete, OpSuspend, OpResume: begin
              state_d = S_ACT_RD;
            end
            OpTick: begin
              pend_d.status = ResNoneFired;
              state_d       = S_TK_RD;
            end
            default: begin
              pend_d.status = ResDone;
              state_d       = S_FIN;
            end
          endcase
        end
      end

      S_ADD: begin
        if (!tbl_valid_i[e_q]) begin
          tbl_we_o           = 1'b1;
          tbl_wdata_o.st     = (delay_q == 16'd0) ? StReady : StWaiting;
          tbl_wdata_o.delay  = delay_q;
          tbl_wdata_o.period = period_q;
          tbl_wdata_o.ident  = id_q;
          tbl_vset_o         = 1'b1;
          pend_d.status      = ResAdded;
          state_d            = S_FIN;
        end else if (last_slot) begin
          pend_d.status = ResNotAdded;
          state_d       = S_FIN;
        end else begin
          sl_d = sl_q + 1'b1;
          e_d  = e_q + 1'b1;
        end
      end

      S_ACT_RD: begin
        tbl_re_o = 1'b1;
        state_d  = S_ACT_EV;
      end

      S_ACT_EV: begin
        if (!found_q && (tbl_rdata_i.ident == id_q)) begin
          found_d = 1'b1;
          if (op_q == OpDelete) begin
            tbl_vclr_o = 1'b1;
          end else begin
            tbl_we_o       = 1'b1;
            tbl_wdata_o.st = (op_q == OpSuspend) ? StSuspended : StReady;
          end
        end
        e_d = e_q + 1'b1;
        if (last_slot) begin
          sl_d    = '0;
          lv_d    = lv_q + 1'b1;
          found_d = 1'b0;
        end else begin
          sl_d = sl_q + 1'b1;
        end
        if (last_slot && last_lv) begin
          pend_d.status = ResDone;
          state_d       = S_FIN;
        end else begin
          state_d = S_ACT_RD;
        end
      end

      S_TK_RD: begin
        tbl_re_o = 1'b1;
        state_d  = S_TK_EV;
      end

      S_TK_EV: begin
        if (!(fire && pend_fire_q && !out_free)) begin
          if (fire) begin
            if (pend_fire_q) begin
              out_d       = pend_q;
              out_d.last  = 1'b0;
              out_valid_d = 1'b1;
            end
            pend_d.status         = ResFired;
            pend_d.fired_task_id  = tbl_rdata_i.ident;
            pend_d.fired_priority = 8'(lv_q);
            pend_fire_d           = 1'b1;
          end
          if (fire || waiting) begin
            tbl_we_o          = 1'b1;
            tbl_wdata_o.st    = le ? StReady : StWaiting;
            tbl_wdata_o.delay = le ? 16'd0 : diff;
          end
          e_d = e_q + 1'b1;
          if (last_slot) begin
            sl_d = '0;
            lv_d = lv_q + 1'b1;
          end else begin
            sl_d = sl_q + 1'b1;
          end
          state_d = (last_slot && last_lv) ? S_FIN : S_TK_RD;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_d       = pend_q;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OpAdd;
      id_q        <= '0;
      period_q    <= '0;
      delay_q     <= '0;
      lv_q        <= '0;
      sl_q        <= '0;
      e_q         <= '0;
      found_q     <= 1'b0;
      pend_q      <= '0;
      pend_fire_q <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      id_q        <= id_d;
      period_q    <= period_d;
      delay_q     <= delay_d;
      lv_q        <= lv_d;
      sl_q        <= sl_d;
      e_q         <= e_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
      pend_fire_q <= pend_fire_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign tbl_addr_o  = e_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/periodic_priority_task_scheduler.sv
// Periodic task scheduler with a table of LEVELS priority levels of SLOTS slots each. Every
// word on the input stream is one operation (add, delete, suspend, resume or tick); the
// block then goes through the table one entry at a time as the operation needs and is not
// ready meanwhile. An add scans the slots of its level for a free one; an unknown operation
// visits no entry. Delete, suspend, resume and tick visit every entry, each with a read step
// and an evaluate step on the single-port table; ticks use one subtract-and-compare unit. While
// the output stream still holds back the previous word, every operation stalls before its
// final word and a tick also stalls before each further fired-task word. A tick yields
// one word per fired task, lowest level and slot first, or a single no-task-fired word,
// and tlast marks the final word of every operation. The tick length in milliseconds is
// set through the register at address 0.
module periodic_priority_task_scheduler #(
  parameter int unsigned LEVELS = ppts_pkg::DefLevels,
  parameter int unsigned SLOTS  = ppts_pkg::DefSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation, task_id, priority_req, period_ms, first_delay_ms, zero fill
  input  logic [ppts_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, fired_task_id, fired_priority, zero fill
  output logic [ppts_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppts_pkg::ApbAddrW-1:0] paddr,
  input  logic [ppts_pkg::ApbDataW-1:0] pwdata,
  output logic [ppts_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import ppts_pkg::*;

  localparam int unsigned Entries = LEVELS * SLOTS;
  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TickW-1:0]   tick_ms_q;
  logic               cfg_wr;
  in_item_t           in_item;
  out_item_t          out_item;
  logic               tbl_re;
  logic [EW-1:0]      tbl_addr;
  entry_t             tbl_rdata;
  logic               tbl_we;
  entry_t             tbl_wdata;
  logic               tbl_vset;
  logic               tbl_vclr;
  logic [Entries-1:0] tbl_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : {{(ApbDataW - TickW){1'b0}}, tick_ms_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q <= TickW'(1);
    end else if (cfg_wr) begin
      tick_ms_q <= pwdata[TickW-1:0];
    end
  end

  assign in_item       = s_axis_tdata[$bits(in_item_t)-1:0];
  assign m_axis_tdata  = {{(OutDataW - 19){1'b0}}, out_item.fired_priority,
                          out_item.fired_task_id, out_item.status};
  assign m_axis_tlast  = out_item.last;

  ppts_seq #(
    .Levels  (LEVELS),
    .Slots   (SLOTS),
    .Entries (Entries),
    .EW      (EW),
    .LW      (LW),
    .SW      (SW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .tick_ms_i   (tick_ms_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .tbl_re_o    (tbl_re),
    .tbl_addr_o  (tbl_addr),
    .tbl_rdata_i (tbl_rdata),
    .tbl_we_o    (tbl_we),
    .tbl_wdata_o (tbl_wdata),
    .tbl_vset_o  (tbl_vset),
    .tbl_vclr_o  (tbl_vclr),
    .tbl_valid_i (tbl_valid)
  );

  ppts_table #(
    .Entries (Entries),
    .EW      (EW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (tbl_re),
    .raddr_i (tbl_addr),
    .rdata_o (tbl_rdata),
    .we_i    (tbl_we),
    .waddr_i (tbl_addr),
    .wdata_i (tbl_wdata),
    .vset_i  (tbl_vset),
    .vclr_i  (tbl_vclr),
    .vidx_i  (tbl_addr),
    .valid_o (tbl_valid)
  );

endmodule

// File: tb/periodic_priority_task_scheduler_tb.sv
module periodic_priority_task_scheduler_tb;
  import ppts_pkg::*;

  localparam int unsigned Levels  = DefLevels;
  localparam int unsigned Slots   = DefSlots;
  localparam int unsigned Entries = Levels * Slots;

  localparam logic [ApbAddrW-1:0] TickAddr = '0;

  localparam logic [2:0] OpSpare5  = 3'd5;
  localparam logic [2:0] OpSpare6  = 3'd6;
  localparam logic [2:0] OpSpare7  = 3'd7;
  localparam logic [2:0] AnyStatus = 3'd0;

  localparam int NumRows    = 26;
  localparam int NumPhases  = 6;
  localparam int PhaseItems = 60;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [15:0] delay;
    logic        known;
    logic [2:0]  status;
  } dir_row_t;

  // The status is typed in only where it is plain; other rows rely on the scheduler copy below.
  dir_row_t directed [NumRows] = '{
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, ResNoneFired},
    '{OpSpare5,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, ResDone},
    '{OpSpare6,  8'h5A, 8'h01, 16'h1234, 16'h0001, 1'b1, ResDone},
    '{OpSpare7,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, ResDone},
    '{OpAdd,     8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, ResNotAdded},
    '{OpAdd,     8'h01, 8'h04, 16'h0001, 16'h0000, 1'b1, ResNotAdded},
    '{OpAdd,     8'h11, 8'h00, 16'h0000, 16'h0000, 1'b1, ResAdded},
    '{OpAdd,     8'h22, 8'h03, 16'h0003, 16'h0002, 1'b1, ResAdded},
    '{OpAdd,     8'hAA, 8'h03, 16'hFFFF, 16'hFFFF, 1'b1, ResAdded},
    '{OpAdd,     8'h55, 8'h03, 16'h0001, 16'h0001, 1'b1, ResAdded},
    '{OpAdd,     8'h00, 8'h03, 16'h0002, 16'h0000, 1'b1, ResAdded},
    '{OpAdd,     8'h66, 8'h03, 16'h0004, 16'h0000, 1'b1, ResNotAdded},
    '{OpAdd,     8'h77, 8'h01, 16'h0001, 16'h0001, 1'b1, ResAdded},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus},
    '{OpSuspend, 8'h11, 8'h00, 16'h0000, 16'h0000, 1'b1, ResDone},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus},
    '{OpResume,  8'h11, 8'h00, 16'h0000, 16'h0000, 1'b1, ResDone},
    '{OpResume,  8'h22, 8'h00, 16'h0000, 16'h0000, 1'b1, ResDone},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus},
    '{OpDelete,  8'hAA, 8'h00, 16'h0000, 16'h0000, 1'b1, ResDone},
    '{OpDelete,  8'h33, 8'h00, 16'h0000, 16'h0000, 1'b1, ResDone},
    '{OpAdd,     8'h33, 8'h03, 16'h0005, 16'h0000, 1'b1, ResAdded},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus},
    '{OpTick,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, AnyStatus}
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bit                  idle_on = 1'b0;
  int                  mismatches = 0;
  logic [7:0]          id_pool [8];

  logic [TickW-1:0]    tick_ms;
  logic                sched_valid  [Entries];
  logic [1:0]          sched_state  [Entries];
  logic [15:0]         sched_delay  [Entries];
  logic [15:0]         sched_period [Entries];
  logic [7:0]          sched_ident  [Entries];
  out_item_t           report_q [$];

  periodic_priority_task_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void schedule_step(input in_item_t it, output out_item_t words [$]);
    out_item_t  w;
    logic [15:0] t;
    int         lv;
    int         sl;
    int         e;
    bit         hit;
    words = {};
    w = '0;
    t = 16'(tick_ms);
    case (it.operation)
      OpAdd: begin
        w.status = ResNotAdded;
        if (it.priority_req < Levels) begin
          for (sl = 0; sl < Slots; sl++) begin
            e = it.priority_req * Slots + sl;
            if (w.status == ResNotAdded && !sched_valid[e]) begin
              sched_valid[e]  = 1'b1;
              sched_period[e] = it.period_ms;
              sched_delay[e]  = it.first_delay_ms;
              sched_ident[e]  = it.task_id;
              sched_state[e]  = (it.first_delay_ms == 16'd0) ? StReady : StWaiting;
              w.status = ResAdded;
            end
          end
        end
        words.push_back(w);
      end
      OpDelete, OpSuspend, OpResume: begin
        for (lv = 0; lv < Levels; lv++) begin
          hit = 1'b0;
          for (sl = 0; sl < Slots; sl++) begin
            e = lv * Slots + sl;
            if (!hit && sched_ident[e] == it.task_id) begin
              hit = 1'b1;
              if (it.operation == OpDelete) sched_valid[e] = 1'b0;
              else if (it.operation == OpSuspend) sched_state[e] = StSuspended;
              else sched_state[e] = StReady;
            end
          end
        end
        w.status = ResDone;
        words.push_back(w);
      end
      OpTick: begin
        for (lv = 0; lv < Levels; lv++) begin
          for (sl = 0; sl < Slots; sl++) begin
            e = lv * Slots + sl;
            if (sched_valid[e] && sched_state[e] == StReady) begin
              w.status = ResFired;
              w.fired_task_id = sched_ident[e];
              w.fired_priority = 8'(lv);
              words.push_back(w);
              if (sched_period[e] <= t) begin
                sched_delay[e] = 16'd0;
              end else begin
                sched_delay[e] = sched_period[e] - t;
                sched_state[e] = StWaiting;
              end
            end else if (sched_valid[e] && sched_state[e] == StWaiting) begin
              if (sched_delay[e] <= t) begin
                sched_delay[e] = 16'd0;
                sched_state[e] = StReady;
              end else begin
                sched_delay[e] = sched_delay[e] - t;
              end
            end
          end
        end
        if (words.size() == 0) begin
          w.status = ResNoneFired;
          words.push_back(w);
        end
      end
      default: begin
        w.status = ResDone;
        words.push_back(w);
      end
    endcase
    w = words.pop_back();
    w.last = 1'b1;
    words.push_back(w);
  endfunction

  function automatic logic [15:0] random_span();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 3 * tick_ms + 3));
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.task_id        = ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_pool[$urandom_range(0, 7)];
    it.priority_req   = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, Levels - 1));
    it.period_ms      = random_span();
    it.first_delay_ms = random_span();
    if (pick < 25) it.operation = OpAdd;
    else if (pick < 63) it.operation = OpTick;
    else if (pick < 78) it.operation = OpDelete;
    else if (pick < 86) it.operation = OpSuspend;
    else if (pick < 94) it.operation = OpResume;
    else it.operation = 3'($urandom_range(OpSpare5, OpSpare7));
    return it;
  endfunction

  task automatic send_word(input in_item_t it, input bit known, input logic [2:0] status);
    out_item_t words [$];
    out_item_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    schedule_step(it, words);
    if (known) begin
      w = '0;
      w.status = status;
      w.last = 1'b1;
      report_q.push_back(w);
    end else begin
      foreach (words[i]) report_q.push_back(words[i]);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_tick(input logic [TickW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TickAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tick_ms = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== ApbDataW'(value)) begin
      $display("%0t: tick_ms read back expected %0d, got %0d", $time, value, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    int stall_left;
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
    m_axis_tready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = out_item_t'({m_axis_tlast, m_axis_tdata[18:0]});
      if (report_q.size() == 0) begin
        $display("%0t: unexpected word, got status %0d id %02h prio %0d last %0b",
                 $time, got.status, got.fired_task_id, got.fired_priority, got.last);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (got.status !== want.status || got.fired_task_id !== want.fired_task_id ||
            got.fired_priority !== want.fired_priority || got.last !== want.last) begin
          $display("%0t: expected status %0d id %02h prio %0d last %0b,",
                   $time, want.status, want.fired_task_id, want.fired_priority, want.last,
                   " got status %0d id %02h prio %0d last %0b",
                   got.status, got.fired_task_id, got.fired_priority, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [TickW-1:0] phase_tick [NumPhases];
    in_item_t         it;
    tick_ms = 6'd1;
    for (int e = 0; e < Entries; e++) begin
      sched_valid[e]  = 1'b0;
      sched_state[e]  = StReady;
      sched_delay[e]  = 16'd0;
      sched_period[e] = 16'd0;
      sched_ident[e]  = 8'd0;
    end
    foreach (id_pool[i]) id_pool[i] = 8'($urandom);
    phase_tick = '{6'd0, 6'd63, 6'd32, 6'($urandom_range(1, 32)), 6'd1, 6'($urandom_range(0, 63))};

    repeat (2) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk_i);

    foreach (directed[r]) begin
      it.operation      = directed[r].op;
      it.task_id        = directed[r].id;
      it.priority_req   = directed[r].prio;
      it.period_ms      = directed[r].period;
      it.first_delay_ms = directed[r].delay;
      send_word(it, directed[r].known, directed[r].status);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      program_tick(phase_tick[ph]);
      idle_on = (ph != 2 && ph != NumPhases - 1);
      repeat (PhaseItems) send_word(random_item(), 1'b0, AnyStatus);
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
